// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
// Each macro collapses to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition leads to another one on the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst, cond, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)

`define ASSERT_NEXT(lbl, clk, rst, cond, expr, msg)

`endif

`endif

// ===== rtl/ucfp_pkg.sv =====
`timescale 1ns / 1ps

package ucfp_pkg;

   // Characters of the frame syntax
   localparam logic [7:0] CharC     = 8'h43;
   localparam logic [7:0] CharM     = 8'h4D;
   localparam logic [7:0] CharD     = 8'h44;
   localparam logic [7:0] CharDash  = 8'h2D;
   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharColon = 8'h3A;
   localparam logic [7:0] CharA     = 8'h41;
   localparam logic [7:0] CharF     = 8'h46;
   localparam logic [7:0] Char0     = 8'h30;
   localparam logic [7:0] Char9     = 8'h39;
   localparam logic [3:0] HexTen    = 4'd10;

   // Stored name length
   localparam int unsigned NameMax = 5;

   // Parameter byte positions after the colon
   localparam logic [2:0] ParamOneLen = 3'd4;
   localparam logic [2:0] ParamTwoPos = 3'd5;
   localparam logic [2:0] ParamSat    = 3'd6;

   // Command codes
   localparam logic [1:0] CmdUnknown = 2'd0;
   localparam logic [1:0] CmdFtnw    = 2'd1;
   localparam logic [1:0] CmdRelay   = 2'd2;
   localparam logic [1:0] CmdTemp    = 2'd3;

   typedef enum logic [2:0] {
      PH_WAIT_C    = 3'd0,
      PH_WAIT_M    = 3'd1,
      PH_WAIT_D    = 3'd2,
      PH_WAIT_DASH = 3'd3,
      PH_BODY      = 3'd4
   } phase_type;

   typedef logic [NameMax-1:0][7:0] name_type;

   typedef struct packed {
      logic       legal;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic [1:0]  cmd_code;
      logic        has_params;
      logic [15:0] param_one;
      logic [3:0]  param_two;
      logic        digit_error;
   } result_type;

   // Hunt phase after a byte that broke the prefix match
   function automatic phase_type restart_phase(input logic [7:0] b);
      return (b == CharC) ? PH_WAIT_M : PH_WAIT_C;
   endfunction

   // Hex digit value; illegal bytes give zero and clear legal
   function automatic hex_type hex_digit(input logic [7:0] b);
      hex_type h;
      h.legal = 1'b1;
      h.value = 4'd0;
      if (b >= CharA && b <= CharF) begin
         h.value = 4'(b - CharA) + HexTen;
      end else if (b >= Char0 && b <= Char9) begin
         h.value = 4'(b - Char0);
      end else begin
         h.legal = 1'b0;
      end
      return h;
   endfunction

   // Prefix match of the stored name against the known commands
   function automatic logic [1:0] decode_name(input name_type n);
      logic [1:0] code;
      code = CmdUnknown;
      if (n[0] == 8'h46 && n[1] == 8'h54 && n[2] == 8'h4E && n[3] == 8'h57) begin
         code = CmdFtnw;
      end else if (n[0] == 8'h52 && n[1] == 8'h45 && n[2] == 8'h4C && n[3] == 8'h41
                   && n[4] == 8'h59) begin
         code = CmdRelay;
      end else if (n[0] == 8'h54 && n[1] == 8'h45 && n[2] == 8'h4D && n[3] == 8'h50) begin
         code = CmdTemp;
      end
      return code;
   endfunction

endpackage

// ===== rtl/ucfp_frame.sv =====
`timescale 1ns / 1ps

module ucfp_frame import ucfp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   output logic       frame_end,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   name_type    name_ff;
   logic [2:0]  name_count_ff;
   logic        in_param_ff;
   logic [2:0]  param_count_ff;
   logic [15:0] first_ff;
   logic [3:0]  second_ff;
   logic        error_ff;

   logic        start_frame;
   logic        in_body;
   logic        clear;
   logic        name_wr;
   logic        colon;
   logic        param_step;
   hex_type     hex;

   // Advance the prefix hunt
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_WAIT_M:    phase_in = (rx_byte == CharM) ? PH_WAIT_D : restart_phase(rx_byte);
            PH_WAIT_D:    phase_in = (rx_byte == CharD) ? PH_WAIT_DASH
                                                        : restart_phase(rx_byte);
            PH_WAIT_DASH: phase_in = (rx_byte == CharDash) ? PH_BODY
                                                           : restart_phase(rx_byte);
            PH_BODY:      phase_in = (rx_byte == CharCr) ? PH_WAIT_C : PH_BODY;
            default:      phase_in = restart_phase(rx_byte);
         endcase
      end
   end

   // Decode phase actions
   always_comb begin
      start_frame = 1'b0;
      in_body     = 1'b0;
      case (phase_ff)
         PH_WAIT_DASH: start_frame = accept && (rx_byte == CharDash);
         PH_BODY:      in_body     = 1'b1;
         default: ;
      endcase
   end

   // Body byte classification
   assign frame_end  = in_body && (rx_byte == CharCr);
   assign clear      = start_frame || (accept && frame_end);
   assign name_wr    = accept && in_body && !frame_end && !in_param_ff
                       && (rx_byte != CharColon) && (name_count_ff < 3'(NameMax));
   assign colon      = accept && in_body && !frame_end && !in_param_ff
                       && (rx_byte == CharColon);
   assign param_step = accept && in_body && !frame_end && in_param_ff;
   assign hex        = hex_digit(rx_byte);

   // Update frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_WAIT_C;
         name_ff        <= '0;
         name_count_ff  <= '0;
         in_param_ff    <= 1'b0;
         param_count_ff <= '0;
         first_ff       <= '0;
         second_ff      <= '0;
         error_ff       <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (clear) begin
            name_ff        <= '0;
            name_count_ff  <= '0;
            in_param_ff    <= 1'b0;
            param_count_ff <= '0;
            first_ff       <= '0;
            second_ff      <= '0;
            error_ff       <= 1'b0;
         end else begin
            if (name_wr) begin
               name_ff[name_count_ff] <= rx_byte;
               name_count_ff          <= name_count_ff + 3'd1;
            end
            if (colon) begin
               in_param_ff <= 1'b1;
            end
            if (param_step) begin
               if (param_count_ff < ParamOneLen) begin
                  first_ff <= {first_ff[11:0], hex.value};
                  if (!hex.legal) begin
                     error_ff <= 1'b1;
                  end
               end else if (param_count_ff == ParamTwoPos) begin
                  second_ff <= hex.value;
                  if (!hex.legal) begin
                     error_ff <= 1'b1;
                  end
               end
               if (param_count_ff < ParamSat) begin
                  param_count_ff <= param_count_ff + 3'd1;
               end
            end
         end
      end
   end

   // Build the result; missing digits count as errors
   always_comb begin
      result.cmd_code    = decode_name(name_ff);
      result.has_params  = in_param_ff;
      result.param_one   = first_ff;
      result.param_two   = second_ff;
      result.digit_error = error_ff || (in_param_ff && ((param_count_ff < ParamOneLen)
                                                      || (param_count_ff == ParamTwoPos)));
   end

endmodule

// ===== rtl/ucfp_out_reg.sv =====
`timescale 1ns / 1ps

module ucfp_out_reg import ucfp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output result_type rsp_result
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   // Hold the item until taken, load a new one when offered
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = data_ff;

endmodule

// ===== rtl/uart_command_frame_parser.sv =====
`timescale 1ns / 1ps
// A result item appears in the cycle after the carriage return that ends its frame is accepted.
// Throughput: one byte per cycle; every byte updates the frame registers in a single pass.
// Input stalls only for a carriage return while a waiting result item is itself stalled.
// Reset (synchronous, active high) returns to hunting for the prefix and clears the frame
// registers and the result valid flag.
`include "assert_macros.svh"

module uart_command_frame_parser import ucfp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_cmd_code,
   output logic        rsp_has_params,
   output logic [15:0] rsp_param_one,
   output logic [3:0]  rsp_param_two,
   output logic        rsp_digit_error
);

   logic       accept;
   logic       frame_end;
   logic       fire;
   logic       overwrite;
   logic       stray_params;
   result_type result;
   result_type rsp_result;

   // Stall only a frame end that cannot reach the result register
   assign req_stall = rsp_valid && rsp_stall && frame_end;
   assign accept    = req_valid && !req_stall;
   assign fire      = accept && frame_end;

   ucfp_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .frame_end (frame_end),
      .result    (result)
   );

   ucfp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .result     (result),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   assign rsp_cmd_code    = rsp_result.cmd_code;
   assign rsp_has_params  = rsp_result.has_params;
   assign rsp_param_one   = rsp_result.param_one;
   assign rsp_param_two   = rsp_result.param_two;
   assign rsp_digit_error = rsp_result.digit_error;

   // Flag conditions watched by the checks below
   assign overwrite    = rsp_valid && rsp_stall && fire;
   assign stray_params = rsp_valid && !rsp_has_params
                         && (rsp_digit_error || (rsp_param_one != 16'd0)
                             || (rsp_param_two != 4'd0));

   // A finished frame always shows up on the result channel
   `ASSERT_NEXT(a_fire_valid, clock, reset, fire, rsp_valid, "frame end lost")
   // Never overwrite an item that is still waiting
   `ASSERT_ALWAYS(a_no_overwrite, clock, reset, !overwrite, "result overwritten")
   // Parameters and errors only exist after a colon
   `ASSERT_ALWAYS(a_no_colon, clock, reset, !stray_params, "params without colon")

endmodule
